/* rtl/ssrp_pkg.sv */
package ssrp_pkg;

  // header byte value and frame layout
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam int         IDX_ID     = 2;
  localparam int         IDX_LEN    = 3;
  localparam int         IDX_STATE  = 4;
  localparam int         PARAM_BASE = 5;
  localparam int         LEN_EXTRA  = 2;
  localparam int         OUT_PARAMS = 6;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_BAD_SUM = 3'd4
  } status_t;

  typedef enum logic {
    REQ_BYTE   = 1'b0,
    REQ_WINDOW = 1'b1
  } req_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic [7:0]                servo_id;
    logic [7:0]                servo_state;
    logic [8*OUT_PARAMS-1:0]   param_bytes;
  } out_word_t;

endpackage

/* rtl/ssrp_in_stage.sv */
module ssrp_in_stage
  import ssrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     adv,
  output logic     fire,
  output in_word_t word
);

  logic     valid_r;
  in_word_t word_r;

  // hold the word while the result side cannot move
  assign in_stall = valid_r && !adv;
  assign fire     = valid_r && adv;
  assign word     = word_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word_r <= in_data;
    end
  end

endmodule

/* rtl/ssrp_core.sv */
module ssrp_core
  import ssrp_pkg::*;
#(
  parameter int MAX_PARAMS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic [2:0] cfg_data,
  input  logic      fire,
  input  in_word_t  word,
  output logic      res_valid,
  output out_word_t res
);

  localparam logic [2:0] MAX_CNT = (MAX_PARAMS > 7) ? 3'd7 : 3'(MAX_PARAMS);

  logic [2:0] param_count_r;
  logic [3:0] byte_index_r, byte_index_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       header_bad_r, header_bad_nxt;
  logic       length_bad_r, length_bad_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] state_r, state_nxt;
  logic [7:0] params_r   [MAX_PARAMS];
  logic [7:0] params_nxt [MAX_PARAMS];
  logic       done_r, done_nxt;

  logic [2:0] cnt;
  logic [3:0] last;
  logic [7:0] b;
  logic [8*OUT_PARAMS-1:0] masked;

  // effective parameter count and checksum position
  assign cnt  = (param_count_r > MAX_CNT) ? MAX_CNT : param_count_r;
  assign last = 4'(PARAM_BASE) + {1'b0, cnt};
  assign b    = word.rx_byte;

  // parameter bytes past the count read as zero
  for (genvar g = 0; g < OUT_PARAMS; g++) begin : g_mask
    if (g < MAX_PARAMS) begin : g_have
      assign masked[8*g +: 8] = (3'(g) < cnt) ? params_r[g] : 8'h00;
    end else begin : g_none
      assign masked[8*g +: 8] = 8'h00;
    end
  end

  // frame parsing for one word
  always_comb begin
    byte_index_nxt = byte_index_r;
    sum_nxt        = sum_r;
    header_bad_nxt = header_bad_r;
    length_bad_nxt = length_bad_r;
    id_nxt         = id_r;
    state_nxt      = state_r;
    params_nxt     = params_r;
    done_nxt       = done_r;
    res_valid      = 1'b0;
    res            = '0;
    res.status     = ST_OK;

    if (word.req_type == REQ_WINDOW) begin
      // window end: rearm, report a short frame unless one completed
      byte_index_nxt = '0;
      sum_nxt        = '0;
      header_bad_nxt = 1'b0;
      length_bad_nxt = 1'b0;
      id_nxt         = '0;
      state_nxt      = '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params_nxt[i] = '0;
      end
      done_nxt = 1'b0;
      if (!done_r) begin
        res_valid  = 1'b1;
        res.status = ST_SHORT;
      end
    end else if (!done_r) begin
      if (byte_index_r >= last) begin
        // checksum byte closes the frame
        done_nxt  = 1'b1;
        res_valid = 1'b1;
        if (header_bad_r) begin
          res.status = ST_BAD_HDR;
        end else if (length_bad_r) begin
          res.status = ST_BAD_LEN;
        end else if (b != ~sum_r) begin
          res.status = ST_BAD_SUM;
        end else begin
          res.status      = ST_OK;
          res.servo_id    = id_r;
          res.servo_state = state_r;
          res.param_bytes = masked;
        end
      end else begin
        if (byte_index_r < 4'(IDX_ID)) begin
          if (b != HDR_BYTE) begin
            header_bad_nxt = 1'b1;
          end
        end else begin
          sum_nxt = sum_r + b;
          if (byte_index_r == 4'(IDX_ID)) begin
            id_nxt = b;
          end
          if (byte_index_r == 4'(IDX_LEN) && b != (8'(cnt) + 8'(LEN_EXTRA))) begin
            length_bad_nxt = 1'b1;
          end
          if (byte_index_r == 4'(IDX_STATE)) begin
            state_nxt = b;
          end
          for (int i = 0; i < MAX_PARAMS; i++) begin
            if (byte_index_r == 4'(PARAM_BASE + i)) begin
              params_nxt[i] = b;
            end
          end
        end
        byte_index_nxt = byte_index_r + 4'd1;
      end
    end
  end

  // parameter count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_count_r <= '0;
    end else if (cfg_valid) begin
      param_count_r <= cfg_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      sum_r        <= '0;
      header_bad_r <= 1'b0;
      length_bad_r <= 1'b0;
      id_r         <= '0;
      state_r      <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params_r[i] <= '0;
      end
      done_r <= 1'b0;
    end else if (fire) begin
      byte_index_r <= byte_index_nxt;
      sum_r        <= sum_nxt;
      header_bad_r <= header_bad_nxt;
      length_bad_r <= length_bad_nxt;
      id_r         <= id_nxt;
      state_r      <= state_nxt;
      params_r     <= params_nxt;
      done_r       <= done_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // window end always rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    fire && word.req_type == REQ_WINDOW |=> byte_index_r == '0 && !done_r && sum_r == '0)
    else $error("parser not rearmed after window end");

  // bytes after a completed frame give nothing
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && word.req_type == REQ_BYTE |-> !res_valid)
    else $error("result produced after completed frame");

  // failure results carry no frame contents
  a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_OK |->
      res.servo_id == '0 && res.servo_state == '0 && res.param_bytes == '0)
    else $error("failure result carries frame data");

  // a completed frame leaves done set
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && word.req_type == REQ_BYTE |=> done_r)
    else $error("frame end did not set done");
`endif

endmodule

/* rtl/ssrp_out_stage.sv */
module ssrp_out_stage
  import ssrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      res_valid,
  input  out_word_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t data_r;

  // the register moves when empty or being taken
  assign adv       = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fire && res_valid) begin
      data_r <= res;
    end
  end

endmodule

/* rtl/servo_status_reply_parser.sv */
// channel | direction | ports                          | word
// in      | input     | in_valid, in_stall, in_data    | in_word_t (req_type, rx_byte)
// out     | output    | out_valid, out_stall, out_data | out_word_t (status, id, state, params)
// cfg     | input     | cfg_valid, cfg_ready, cfg_data | param_count, 3 bits
//
// one word is accepted every cycle unless in_stall is high; it is held in the input register,
// and the parser result loads the result register when that register can move, so out_valid
// rises for words that give a result, and the result is taken while out_stall is low
// synchronous active-low reset clears the handshake and all frame state, param_count to 0
// in_stall rises only while both registers are full and out_stall holds the result
// cfg_ready is always high; the count takes effect on the next word parsed
module servo_status_reply_parser
  import ssrp_pkg::*;
#(
  parameter int MAX_PARAMS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic      adv;
  logic      fire;
  in_word_t  word;
  logic      res_valid;
  out_word_t res;

  assign cfg_ready = 1'b1;

  ssrp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .fire     (fire),
    .word     (word)
  );

  ssrp_core #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  ssrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
